// ===== rtl/keypad_debounce_event_latch_macros.svh =====
// ----------------------------------------------------------------------------
// keypad_debounce_event_latch_macros.svh
// Assertion macros for the keypad debouncer. Expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DEBOUNCE_EVENT_LATCH_MACROS_SVH
`define KEYPAD_DEBOUNCE_EVENT_LATCH_MACROS_SVH

// property checked on every clock edge outside reset
`define KDEL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define KDEL_ASSERT_NEVER(label, cond, msg) \
	`KDEL_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/kdel_pkg.sv =====
// ----------------------------------------------------------------------------
// kdel_pkg
// Types and constants shared by the keypad debouncer files.
// ----------------------------------------------------------------------------
`default_nettype none

package kdel_pkg;

	localparam int FIELD_W       = 12;
	localparam int CNT_W         = 8;
	localparam int KEY_COUNT_DEF = 12;
	localparam int KEY_COUNT_MAX = 16;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd5;

	typedef logic [FIELD_W-1:0] keymap_t;
	typedef logic [CNT_W-1:0]   count_t;

	typedef enum logic [1:0] {
		CMD_SCAN    = 2'd0,
		CMD_PRESS   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		keymap_t    raw_keys;
		keymap_t    key_mask;
	} in_word_t;

	typedef struct packed {
		keymap_t pressed_keys;
		keymap_t press_pending;
		keymap_t release_pending;
		logic    consumed_any;
	} out_word_t;

endpackage

`default_nettype wire

// ===== rtl/kdel_if.sv =====
// ----------------------------------------------------------------------------
// kdel_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdel_in_if;
	logic             valid;
	logic             ready;
	logic [1:0]       command;
	kdel_pkg::keymap_t raw_keys;
	kdel_pkg::keymap_t key_mask;

	modport source (output valid, output command, output raw_keys, output key_mask,
		input ready);
	modport sink (input valid, input command, input raw_keys, input key_mask,
		output ready);
endinterface

interface kdel_out_if;
	logic             valid;
	logic             ready;
	kdel_pkg::keymap_t pressed_keys;
	kdel_pkg::keymap_t press_pending;
	kdel_pkg::keymap_t release_pending;
	logic             consumed_any;

	modport source (output valid, output pressed_keys, output press_pending,
		output release_pending, output consumed_any, input ready);
	modport sink (input valid, input pressed_keys, input press_pending,
		input release_pending, input consumed_any, output ready);
endinterface

`default_nettype wire

// ===== rtl/keypad_debounce_event_latch.sv =====
// ----------------------------------------------------------------------------
// keypad_debounce_event_latch
// Keypad debouncer with latched one-shot press and release events.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word is registered in s1, processed in one pass and
//   lands in the s2 result register when s1 advances.
// Throughput: one word per cycle; s1 advances whenever s2 is empty or drained.
// Reset: counters and stable map clear, taken maps set to all keys, pending
//   maps clear, limit returns to 5, both stages empty.
`default_nettype none

`include "keypad_debounce_event_latch_macros.svh"

module keypad_debounce_event_latch #(
	parameter int KEY_COUNT = kdel_pkg::KEY_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             limit_we,
	input  wire kdel_pkg::count_t limit_wdata,
	kdel_in_if.sink               request,
	kdel_out_if.source            result
);

	localparam int LIVE_KEYS =
		(KEY_COUNT < kdel_pkg::FIELD_W) ? KEY_COUNT : kdel_pkg::FIELD_W;
	localparam logic [kdel_pkg::FIELD_W:0] OneWide = 1;
	localparam kdel_pkg::keymap_t LiveMask =
		kdel_pkg::keymap_t'((OneWide << LIVE_KEYS) - OneWide);

	kdel_pkg::count_t   limit_q;
	kdel_pkg::in_word_t word_s1;
	logic               valid_s1;
	kdel_pkg::out_word_t out_s2;
	logic               valid_s2;

	kdel_pkg::keymap_t stable_q, press_taken_q, release_taken_q;
	kdel_pkg::keymap_t press_ready_q, release_ready_q;
	kdel_pkg::keymap_t stable_n, press_taken_n, release_taken_n;
	kdel_pkg::keymap_t press_ready_n, release_ready_n;
	kdel_pkg::keymap_t bank_stable, rose, fell, hit;
	kdel_pkg::cmd_t    cmd;
	logic              adv_s1, in_ready, tick;

	assign adv_s1   = valid_s1 && (!valid_s2 || result.ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign cmd      = kdel_pkg::cmd_t'(word_s1.command);
	assign tick     = adv_s1 && (cmd == kdel_pkg::CMD_SCAN);

	assign request.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= kdel_pkg::LIMIT_RESET;
		else if (limit_we)
			limit_q <= limit_wdata;
	end

	kdel_counter_bank #(
		.LIVE_KEYS(LIVE_KEYS)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.raw_keys   (word_s1.raw_keys & LiveMask),
		.limit      (limit_q),
		.stable_keys(stable_q),
		.stable_next(bank_stable)
	);

	assign rose = bank_stable & ~stable_q;
	assign fell = ~bank_stable & stable_q;

	always_comb begin
		stable_n        = stable_q;
		press_taken_n   = press_taken_q;
		release_taken_n = release_taken_q;
		press_ready_n   = press_ready_q;
		release_ready_n = release_ready_q;
		hit             = '0;
		unique case (cmd)
			kdel_pkg::CMD_SCAN: begin
				stable_n        = bank_stable;
				press_taken_n   = press_taken_q & ~fell;
				release_taken_n = release_taken_q & ~rose;
				press_ready_n   = bank_stable & ~press_taken_n;
				release_ready_n = ~bank_stable & ~release_taken_n & LiveMask;
			end
			kdel_pkg::CMD_PRESS: begin
				hit           = word_s1.key_mask & press_ready_q;
				press_taken_n = press_taken_q | hit;
				press_ready_n = press_ready_q & ~hit;
			end
			kdel_pkg::CMD_RELEASE: begin
				hit             = word_s1.key_mask & release_ready_q;
				release_taken_n = release_taken_q | hit;
				release_ready_n = release_ready_q & ~hit;
				// re-arm the next press of a released key
				press_taken_n   = press_taken_q & ~hit;
			end
			kdel_pkg::CMD_NONE: begin
				hit = '0;
			end
			default: begin
				hit = '0;
			end
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= request.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && request.valid) begin
			word_s1.command  <= request.command;
			word_s1.raw_keys <= request.raw_keys;
			word_s1.key_mask <= request.key_mask;
		end
	end

	// event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q        <= '0;
			press_taken_q   <= LiveMask;
			release_taken_q <= LiveMask;
			press_ready_q   <= '0;
			release_ready_q <= '0;
		end else if (adv_s1) begin
			stable_q        <= stable_n;
			press_taken_q   <= press_taken_n;
			release_taken_q <= release_taken_n;
			press_ready_q   <= press_ready_n;
			release_ready_q <= release_ready_n;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1)
			valid_s2 <= 1'b1;
		else if (result.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_s2.pressed_keys    <= stable_n;
			out_s2.press_pending   <= press_ready_n;
			out_s2.release_pending <= release_ready_n;
			out_s2.consumed_any    <= (hit != '0);
		end
	end

	assign result.valid           = valid_s2;
	assign result.pressed_keys    = out_s2.pressed_keys;
	assign result.press_pending   = out_s2.press_pending;
	assign result.release_pending = out_s2.release_pending;
	assign result.consumed_any    = out_s2.consumed_any;

	`KDEL_ASSERT_NEVER(a_press_pending_stable, valid_s2 && ((out_s2.press_pending & ~out_s2.pressed_keys) != '0), "press event on a key that is not pressed")
	`KDEL_ASSERT_NEVER(a_release_pending_stable, valid_s2 && ((out_s2.release_pending & out_s2.pressed_keys) != '0), "release event on a pressed key")
	`KDEL_ASSERT_NEVER(a_ready_not_taken, (press_ready_q & press_taken_q) != '0, "press event both pending and taken")
	`KDEL_ASSERT(a_advance_fills, adv_s1 |=> valid_s2, "result word lost after advance")

endmodule

`default_nettype wire

// ===== rtl/kdel_counter_bank.sv =====
// ----------------------------------------------------------------------------
// kdel_counter_bank
// Integrating counters, one per key, and the next stable key map.
// ----------------------------------------------------------------------------
`default_nettype none

module kdel_counter_bank #(
	parameter int LIVE_KEYS = kdel_pkg::KEY_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire kdel_pkg::keymap_t raw_keys,
	input  wire kdel_pkg::count_t  limit,
	input  wire kdel_pkg::keymap_t stable_keys,
	output kdel_pkg::keymap_t      stable_next
);

	kdel_pkg::count_t count_q    [LIVE_KEYS];
	kdel_pkg::count_t count_next [LIVE_KEYS];

	always_comb begin
		stable_next = '0;
		for (int k = 0; k < LIVE_KEYS; k++) begin
			count_next[k] = count_q[k];
			if (raw_keys[k]) begin
				if (count_q[k] < limit)
					count_next[k] = kdel_pkg::count_t'(count_q[k] + 1'b1);
				// limit zero accepts at once
				stable_next[k] = (count_next[k] >= limit) ? 1'b1 : stable_keys[k];
			end else begin
				if (count_q[k] != '0)
					count_next[k] = kdel_pkg::count_t'(count_q[k] - 1'b1);
				stable_next[k] = (count_next[k] == '0) ? 1'b0 : stable_keys[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LIVE_KEYS; k++)
				count_q[k] <= '0;
		end else if (tick) begin
			for (int k = 0; k < LIVE_KEYS; k++)
				count_q[k] <= count_next[k];
		end
	end

endmodule

`default_nettype wire
